// ----- hw/rtl/nmea_sentence_parser_macros.svh -----
// Assertion macros for the NMEA sentence parser.
// Uses the clk and rst_n names of the module that includes it.
`ifndef NMEA_SENTENCE_PARSER_MACROS_SVH
`define NMEA_SENTENCE_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define NSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define NSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/nsp_pkg.sv -----
// Package for the NMEA sentence parser: characters, slot defaults, types.
// No dependencies.
package nsp_pkg;

  localparam int ID_W      = 40;
  localparam int NUM_SLOTS = 6;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int FIELD_W   = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Identifier length and the value that marks a bad hex digit
  localparam logic [2:0] ID_CHARS = 3'd5;
  localparam logic [4:0] HEX_BAD  = 5'd16;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [KIND_W-1:0] kind_t;

  // Slot defaults: GPGGA, GPGLL, GPGSA, GPGSV, GPRMC, GPVTG
  localparam id_t SLOT_RESET [NUM_SLOTS] = '{
    40'd306289526593, 40'd306289527884, 40'd306289529665,
    40'd306289529686, 40'd306290249027, 40'd306290512967
  };

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BODY,
    PH_CK_HI,
    PH_CK_LO
  } phase_t;

  // One result request
  typedef struct packed {
    logic               emit;
    logic [7:0]         echo;
    logic [FIELD_W-1:0] field;
    kind_t              kind;
    logic               is_field;
    logic               last;
    logic               good;
  } result_t;

  // Hex digit value, HEX_BAD for anything else
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else                               v = HEX_BAD;
    return v;
  endfunction

endpackage

// ----- hw/rtl/nsp_cfg.sv -----
// Sentence ID slot registers and the identifier match against them.
// Depends on nsp_pkg.
module nsp_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [nsp_pkg::CFG_IDX_W-1:0] wr_index,
  input  nsp_pkg::id_t               wr_data,
  input  nsp_pkg::id_t               id_cand,
  output nsp_pkg::kind_t             match_kind
);
  import nsp_pkg::*;

  id_t slot_r [NUM_SLOTS];

  // Slot writes; indexes past the last slot are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) slot_r[k] <= SLOT_RESET[k];
    end else if (wr_en && (int'(wr_index) < NUM_SLOTS)) begin
      slot_r[wr_index] <= wr_data;
    end
  end

  // First equal slot wins: scan from the last down
  always_comb begin
    match_kind = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (id_cand == slot_r[k]) match_kind = KIND_W'(k + 1);
    end
  end

endmodule

// ----- hw/rtl/nsp_core.sv -----
// Per-character sentence state: phase, identifier, field count, XOR sum.
// Depends on nsp_pkg.
module nsp_core #(
  parameter int FIELD_INDEX_MAX = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  nsp_pkg::kind_t   match_kind,
  output nsp_pkg::id_t     id_cand,
  output nsp_pkg::result_t res
);
  import nsp_pkg::*;

  localparam int FC_W = $clog2(FIELD_INDEX_MAX + 1);
  localparam logic [FC_W-1:0] FC_MAX = FC_W'(FIELD_INDEX_MAX);

  phase_t          phase_r,   phase_nxt;
  id_t             idsh_r,    idsh_nxt;
  logic [2:0]      idcnt_r,   idcnt_nxt;
  kind_t           kind_r,    kind_nxt;
  logic [FC_W-1:0] fc_r,      fc_nxt;
  logic [7:0]      xsum_r,    xsum_nxt;
  logic [3:0]      hinib_r,   hinib_nxt;
  logic            hexerr_r,  hexerr_nxt;
  logic [4:0]      hv;

  assign id_cand = {idsh_r[ID_W-9:0], rx_byte};
  assign hv      = hex_value(rx_byte);

  // State registers, updated on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      idsh_r   <= '0;
      idcnt_r  <= '0;
      kind_r   <= '0;
      fc_r     <= '0;
      xsum_r   <= '0;
      hinib_r  <= '0;
      hexerr_r <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      idsh_r   <= idsh_nxt;
      idcnt_r  <= idcnt_nxt;
      kind_r   <= kind_nxt;
      fc_r     <= fc_nxt;
      xsum_r   <= xsum_nxt;
      hinib_r  <= hinib_nxt;
      hexerr_r <= hexerr_nxt;
    end
  end

  // Next state and result
  always_comb begin
    logic clear_all;
    clear_all    = 1'b0;
    phase_nxt    = phase_r;
    idsh_nxt     = idsh_r;
    idcnt_nxt    = idcnt_r;
    kind_nxt     = kind_r;
    fc_nxt       = fc_r;
    xsum_nxt     = xsum_r;
    hinib_nxt    = hinib_r;
    hexerr_nxt   = hexerr_r;
    res          = '0;
    res.emit     = (rx_byte != CH_SPACE);
    res.echo     = rx_byte;

    if (rx_byte == CH_SPACE) begin
      // dropped, state untouched
    end else if (rx_byte == CH_DOLLAR) begin
      clear_all = 1'b1;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          // idle bytes carry only their echo
        end
        PH_BODY: begin
          if (rx_byte == CH_STAR) begin
            phase_nxt = PH_CK_HI;
            idcnt_nxt = ID_CHARS;
          end else begin
            xsum_nxt = xsum_r ^ rx_byte;
            if (rx_byte == CH_COMMA) begin
              idcnt_nxt = ID_CHARS;
              if (fc_r < FC_MAX) fc_nxt = fc_r + 1'b1;
            end else if (idcnt_r < ID_CHARS) begin
              idsh_nxt  = id_cand;
              idcnt_nxt = idcnt_r + 3'd1;
              if (idcnt_r == ID_CHARS - 3'd1) kind_nxt = match_kind;
            end else if (fc_r != '0) begin
              res.is_field = 1'b1;
            end
          end
        end
        PH_CK_HI: begin
          hinib_nxt  = hv[3:0];
          hexerr_nxt = hv[4];
          phase_nxt  = PH_CK_LO;
        end
        PH_CK_LO: begin
          res.last = 1'b1;
          res.good = !hexerr_r && !hv[4] && ({hinib_r, hv[3:0]} == xsum_r);
        end
        default: ;
      endcase
    end

    // Report the updated field and kind; the closing digit keeps the current ones
    res.field = fc_nxt[FIELD_W-1:0];
    res.kind  = kind_nxt;
    if (res.last) begin
      res.field = fc_r[FIELD_W-1:0];
      res.kind  = kind_r;
      phase_nxt = PH_IDLE;
      clear_all = 1'b1;
    end

    if (clear_all) begin
      idsh_nxt   = '0;
      idcnt_nxt  = '0;
      kind_nxt   = '0;
      fc_nxt     = '0;
      xsum_nxt   = '0;
      hinib_nxt  = '0;
      hexerr_nxt = 1'b0;
      if (!res.last) begin
        phase_nxt = PH_BODY;
        res.field = '0;
        res.kind  = '0;
      end
    end
  end

endmodule

// ----- hw/rtl/nmea_sentence_parser.sv -----
// NMEA 0183 sentence parser with XOR checksum check. One character is
// accepted per clock cycle, every cycle, as long as the result register is
// empty or being drained in that cycle; the character is decoded against the
// sentence state in a single pass and its result appears in the output
// register on the next cycle. Spaces are accepted but give no result.
// Six ID slots are written through the cfg port, index 0 to 5,
// first character in bits 39..32; writes take effect on the next cycle.
// Depends on nsp_pkg, nsp_cfg, nsp_core and nmea_sentence_parser_macros.svh.
`include "nmea_sentence_parser_macros.svh"

module nmea_sentence_parser #(
  parameter int FIELD_INDEX_MAX = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input character stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [7:0] echo_byte, [12:8] field_number
  output logic [4:0]                    out_tuser,  // [2:0] sentence_kind, [3] is_field_char,
                                                    // [4] checksum_good
  output logic                          out_tlast,  // sentence_end
  // ID slot writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nsp_pkg::ID_W-1:0]      cfg_data
);
  import nsp_pkg::*;

  logic    in_fire;
  id_t     id_cand;
  kind_t   match_kind;
  result_t res;
  result_t out_r;
  logic    out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  nsp_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_valid),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .id_cand    (id_cand),
    .match_kind (match_kind)
  );

  nsp_core #(
    .FIELD_INDEX_MAX (FIELD_INDEX_MAX)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .rx_byte    (in_tdata),
    .match_kind (match_kind),
    .id_cand    (id_cand),
    .res        (res)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire && res.emit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.field, out_r.echo};
  assign out_tuser  = {out_r.good, out_r.is_field, out_r.kind};
  assign out_tlast  = out_r.last;

  // Checks
  `NSP_ASSERT_NOW(a_good_only_at_end, out_tvalid && out_tuser[4], out_tlast, "checksum_good without sentence end")
  `NSP_ASSERT_NOW(a_end_not_field, out_tvalid && out_tlast, !out_tuser[3], "sentence end flagged as field char")
  `NSP_ASSERT_NEXT(a_space_no_result, in_fire && (in_tdata == CH_SPACE), !out_tvalid, "space produced a result")
  `NSP_ASSERT_NEXT(a_echo, in_fire && (in_tdata != CH_SPACE), out_tvalid && (out_tdata[7:0] == $past(in_tdata)), "result does not echo the accepted byte")

endmodule
